@@ design/rau_pkg.sv @@
// Package with the shared types and codes of the rational arithmetic unit.
`default_nettype none
package rau_pkg;

    localparam int OPW = 32;
    localparam int MAGW = 64;
    localparam int CNTW = 6;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_DZ = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic load;
        logic mul0;
        logic mul1;
        logic mul2;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic dz;
        logic n_zero;
        logic gcd_done;
        logic div_last;
    } stat_t;

    typedef struct packed {
        logic neg;
        logic [OPW-1:0] mag;
    } sm_t;

    function automatic sm_t to_sm(input logic [OPW-1:0] x);
        sm_t s;
        s.neg = x[OPW-1];
        s.mag = x[OPW-1] ? (~x + 1'b1) : x;
        return s;
    endfunction

endpackage
`default_nettype wire

@@ design/rau_dp.sv @@
// Datapath of the rational arithmetic unit: multiplier, gcd and dividers.
`default_nettype none
module rau_dp
    import rau_pkg::*;
(
    input  wire logic         clk,
    input  wire cmd_t         cmd,
    input  wire logic [135:0] in_data,
    output stat_t             stat,
    output logic [71:0]       out_data
);

    logic [2:0]      mode_reg;
    sm_t             an_reg, ad_reg, bn_reg, bd_reg;
    logic            dz_reg;
    logic            n_neg_reg, d_neg_reg, t_neg_reg;
    logic [MAGW-1:0] n_mag_reg, d_mag_reg, t_mag_reg;
    logic [MAGW-1:0] x_reg, y_reg, rn_reg, rd_reg;
    logic [CNTW-1:0] k_reg, cnt_reg;
    logic [OPW-1:0]  rnum_reg, rden_reg;
    logic [1:0]      rst_reg;

    sm_t             in_an, in_ad, in_bn, in_bd, one_sm, mul_a, mul_b;
    logic            neg_mode, prod_nz, prod_neg;
    logic [MAGW-1:0] prod, sum_mag;
    logic            sum_neg;
    logic [MAGW:0]   ns, ds;
    logic            n_ge, d_ge;
    logic            n_fit, d_fit;
    logic [OPW-1:0]  n_enc, d_enc;

    assign in_an = to_sm(in_data[34:3]);
    assign in_ad = to_sm(in_data[66:35]);
    assign in_bn = to_sm(in_data[98:67]);
    assign in_bd = to_sm(in_data[130:99]);
    assign one_sm = '{neg: 1'b0, mag: OPW'(1)};
    assign neg_mode = mode_reg[2];

    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        if (cmd.mul0)
        begin
            mul_a = an_reg;
            if (neg_mode)
                mul_b = one_sm;
            else if (mode_reg == MODE_MUL)
                mul_b = bn_reg;
            else
                mul_b = bd_reg;
        end
        else if (cmd.mul1)
        begin
            mul_a = bn_reg;
            mul_b = ad_reg;
        end
        else
        begin
            mul_a = ad_reg;
            if (neg_mode)
                mul_b = one_sm;
            else if (mode_reg == MODE_DIV)
                mul_b = bn_reg;
            else
                mul_b = bd_reg;
        end
    end

    assign prod = MAGW'(mul_a.mag) * MAGW'(mul_b.mag);
    assign prod_nz = (prod != '0);
    assign prod_neg = prod_nz && (mul_a.neg ^ mul_b.neg);

    always_comb
    begin
        if (n_neg_reg == t_neg_reg)
        begin
            sum_mag = n_mag_reg + t_mag_reg;
            sum_neg = n_neg_reg;
        end
        else if (n_mag_reg >= t_mag_reg)
        begin
            sum_mag = n_mag_reg - t_mag_reg;
            sum_neg = n_neg_reg;
        end
        else
        begin
            sum_mag = t_mag_reg - n_mag_reg;
            sum_neg = t_neg_reg;
        end
        if (sum_mag == '0)
            sum_neg = 1'b0;
    end

    assign ns = {rn_reg, n_mag_reg[MAGW-1]};
    assign ds = {rd_reg, d_mag_reg[MAGW-1]};
    assign n_ge = (ns >= {1'b0, x_reg});
    assign d_ge = (ds >= {1'b0, x_reg});

    assign n_fit = n_neg_reg ? (n_mag_reg <= (MAGW'(1) << (OPW-1)))
                             : (n_mag_reg < (MAGW'(1) << (OPW-1)));
    assign d_fit = d_neg_reg ? (d_mag_reg <= (MAGW'(1) << (OPW-1)))
                             : (d_mag_reg < (MAGW'(1) << (OPW-1)));
    assign n_enc = n_neg_reg ? (~n_mag_reg[OPW-1:0] + 1'b1) : n_mag_reg[OPW-1:0];
    assign d_enc = d_neg_reg ? (~d_mag_reg[OPW-1:0] + 1'b1) : d_mag_reg[OPW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data[2:0];
            an_reg <= in_an;
            ad_reg <= in_ad;
            bn_reg <= in_bn;
            bd_reg <= in_bd;
            dz_reg <= (in_ad.mag == '0) || (!in_data[2] && in_bd.mag == '0)
                      || (in_data[2:0] == MODE_DIV && in_bn.mag == '0);
        end
        if (cmd.mul0)
        begin
            n_mag_reg <= prod;
            n_neg_reg <= prod_neg ^ (neg_mode && prod_nz);
        end
        if (cmd.mul1)
        begin
            t_mag_reg <= prod;
            t_neg_reg <= prod_neg ^ ((mode_reg == MODE_SUB) && prod_nz);
        end
        if (cmd.mul2)
        begin
            d_mag_reg <= prod;
            d_neg_reg <= prod_neg;
            if (mode_reg == MODE_ADD || mode_reg == MODE_SUB)
            begin
                n_mag_reg <= sum_mag;
                n_neg_reg <= sum_neg;
            end
        end
        if (cmd.gcd_init)
        begin
            x_reg <= n_mag_reg;
            y_reg <= d_mag_reg;
            k_reg <= '0;
        end
        if (cmd.gcd_step)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!x_reg[0])
                x_reg <= x_reg >> 1;
            else if (!y_reg[0])
                y_reg <= y_reg >> 1;
            else if (x_reg > y_reg)
                x_reg <= (x_reg - y_reg) >> 1;
            else if (y_reg > x_reg)
                y_reg <= (y_reg - x_reg) >> 1;
        end
        if (cmd.div_init)
        begin
            n_mag_reg <= n_mag_reg >> k_reg;
            d_mag_reg <= d_mag_reg >> k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rn_reg <= n_ge ? MAGW'(ns - {1'b0, x_reg}) : ns[MAGW-1:0];
            rd_reg <= d_ge ? MAGW'(ds - {1'b0, x_reg}) : ds[MAGW-1:0];
            n_mag_reg <= {n_mag_reg[MAGW-2:0], n_ge};
            d_mag_reg <= {d_mag_reg[MAGW-2:0], d_ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            if (dz_reg)
            begin
                rnum_reg <= '0;
                rden_reg <= '0;
                rst_reg <= ST_DZ;
            end
            else if (!n_fit || !d_fit)
            begin
                rnum_reg <= '0;
                rden_reg <= '0;
                rst_reg <= ST_OVF;
            end
            else
            begin
                rnum_reg <= n_enc;
                rden_reg <= d_enc;
                rst_reg <= ST_OK;
            end
        end
    end

    assign stat.dz = dz_reg;
    assign stat.n_zero = (n_mag_reg == '0);
    assign stat.gcd_done = x_reg[0] && y_reg[0] && (x_reg == y_reg);
    assign stat.div_last = (cnt_reg == {CNTW{1'b1}});

    assign out_data = {6'd0, rst_reg, rden_reg, rnum_reg};

endmodule
`default_nettype wire

@@ design/rau_ctrl.sv @@
// Controller state machine of the rational arithmetic unit.
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CHECK = 10'b0000000010,
        S_MUL0  = 10'b0000000100,
        S_MUL1  = 10'b0000001000,
        S_MUL2  = 10'b0000010000,
        S_GINIT = 10'b0000100000,
        S_GCD   = 10'b0001000000,
        S_SHIFT = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: state_next = stat.dz ? S_FIN : S_MUL0;
            S_MUL0:
            begin
                cmd.mul0 = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2 = 1'b1;
                state_next = S_GINIT;
            end
            S_GINIT:
            begin
                if (stat.n_zero)
                    state_next = S_FIN;
                else
                begin
                    cmd.gcd_init = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                    state_next = S_SHIFT;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_SHIFT:
            begin
                cmd.div_init = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.out_load)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

`ifndef SYNTHESIS
    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted word did not start the check step");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!ov_reg || out_ready))
        else $error("result register overwritten while full");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_last) |=> (state_reg == S_FIN))
        else $error("division did not end in the finish state");
`endif

endmodule
`default_nettype wire

@@ design/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit with stream ports.
// Each word passes through 3 multiply steps, the gcd steps of the shared subtract
// and shift unit, and 64 restoring divide steps. Division by zero words skip the
// multiply steps; words with a zero numerator skip the gcd and divide steps.
// Throughput: one word at a time; the next word is taken once the result
// sits in the output register. Reset is asynchronous and active low.
`default_nettype none
module rational_arith_unit_top
    import rau_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,  // mode, a_num, a_den, b_num, b_den
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata   // res_num, res_den, status
);

    cmd_t  cmd;
    stat_t stat;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rau_dp u_dp (
        .clk      (clk),
        .cmd      (cmd),
        .in_data  (s_tdata),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the rational arithmetic unit with stream ports.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import rau_pkg::*;

    localparam logic [2:0] MODE_NEG = 3'd4;
    localparam int NUM_RANDOM = 1250;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] b_den;
        logic [31:0] b_num;
        logic [31:0] a_den;
        logic [31:0] a_num;
        logic [2:0]  mode;
    } operands_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] res_den;
        logic [31:0] res_num;
    } fraction_t;

    typedef struct {
        logic          neg;
        logic [63:0]   mag;
    } signed_mag_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;

    operands_t pending_ops[$];
    fraction_t expected_fracs[$];
    int  error_count;
    int  idle_cycles;
    bit  stimulus_done;
    bit  quiet_phase;
    int  send_gap;
    int  recv_gap;

    rational_arith_unit_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic signed_mag_t to_signed_mag(input logic [31:0] x);
        signed_mag_t s;
        s.neg = x[31];
        s.mag = x[31] ? {32'd0, (~x + 32'd1)} : {32'd0, x};
        return s;
    endfunction

    function automatic signed_mag_t sm_product(input signed_mag_t a, input signed_mag_t b);
        signed_mag_t r;
        r.mag = a.mag * b.mag;
        r.neg = (r.mag != 0) && (a.neg != b.neg);
        return r;
    endfunction

    function automatic signed_mag_t sm_sum(input signed_mag_t a, input signed_mag_t b);
        signed_mag_t r;
        if (a.neg == b.neg)
        begin
            r.mag = a.mag + b.mag;
            r.neg = a.neg;
        end
        else if (a.mag >= b.mag)
        begin
            r.mag = a.mag - b.mag;
            r.neg = a.neg;
        end
        else
        begin
            r.mag = b.mag - a.mag;
            r.neg = b.neg;
        end
        if (r.mag == 0)
            r.neg = 1'b0;
        return r;
    endfunction

    function automatic signed_mag_t sm_negate(input signed_mag_t a);
        signed_mag_t r;
        r = a;
        if (r.mag != 0)
            r.neg = ~r.neg;
        return r;
    endfunction

    function automatic bit fits_32(input signed_mag_t s);
        return s.neg ? (s.mag <= 64'h8000_0000) : (s.mag < 64'h8000_0000);
    endfunction

    function automatic fraction_t reduce_fraction(input operands_t op);
        signed_mag_t an, ad, bn, bd, n, d;
        logic [63:0] x, y, t;
        fraction_t f;
        an = to_signed_mag(op.a_num);
        ad = to_signed_mag(op.a_den);
        bn = to_signed_mag(op.b_num);
        bd = to_signed_mag(op.b_den);
        f = '0;
        if (ad.mag == 0 || (op.mode < MODE_NEG && bd.mag == 0)
            || (op.mode == MODE_DIV && bn.mag == 0))
        begin
            f.status = ST_DZ;
            return f;
        end
        case (op.mode)
            MODE_ADD:
            begin
                n = sm_sum(sm_product(an, bd), sm_product(bn, ad));
                d = sm_product(ad, bd);
            end
            MODE_SUB:
            begin
                n = sm_sum(sm_product(an, bd), sm_negate(sm_product(bn, ad)));
                d = sm_product(ad, bd);
            end
            MODE_MUL:
            begin
                n = sm_product(an, bn);
                d = sm_product(ad, bd);
            end
            MODE_DIV:
            begin
                n = sm_product(an, bd);
                d = sm_product(ad, bn);
            end
            default:
            begin
                n = sm_negate(an);
                d = ad;
            end
        endcase
        if (n.mag != 0)
        begin
            x = n.mag;
            y = d.mag;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            n.mag = n.mag / x;
            d.mag = d.mag / x;
        end
        if (!fits_32(n) || !fits_32(d))
        begin
            f.status = ST_OVF;
            return f;
        end
        f.res_num = n.neg ? (~n.mag[31:0] + 32'd1) : n.mag[31:0];
        f.res_den = d.neg ? (~d.mag[31:0] + 32'd1) : d.mag[31:0];
        f.status = ST_OK;
        return f;
    endfunction

    function automatic logic [31:0] random_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3, 4: return $urandom_range(0, 40) - 20;
            5, 6: return $urandom_range(0, 2000) - 1000;
            7: return {{16{1'b0}}, 16'($urandom)} - 32'd32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [2:0] mode, input logic [31:0] an, input logic [31:0] ad,
                          input logic [31:0] bn, input logic [31:0] bd);
        operands_t op;
        op.mode = mode;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        pending_ops.push_back(op);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_fracs.push_back(reduce_fraction(operands_t'(s_tdata[130:0])));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_ops.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, pending_ops.pop_front()};
                    if (!quiet_phase && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(1, 15);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_fracs.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    fraction_t exp_f, got_f;
                    exp_f = expected_fracs.pop_front();
                    got_f = fraction_t'(m_tdata[65:0]);
                    if (got_f.res_num !== exp_f.res_num)
                    begin
                        $display("%0t: res_num expected %h actual %h", $time,
                                 exp_f.res_num, got_f.res_num);
                        error_count++;
                    end
                    if (got_f.res_den !== exp_f.res_den)
                    begin
                        $display("%0t: res_den expected %h actual %h", $time,
                                 exp_f.res_den, got_f.res_den);
                        error_count++;
                    end
                    if (got_f.status !== exp_f.status)
                    begin
                        $display("%0t: status expected %h actual %h", $time,
                                 exp_f.status, got_f.status);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 7) == 0)
                    recv_gap <= $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** rational_arith_unit_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] mode;
        error_count = 0;
        idle_cycles = 0;
        quiet_phase = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        add_op(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        add_op(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        add_op(MODE_MUL, -32'd3, 32'd4, 32'd2, -32'd9);
        add_op(MODE_DIV, 32'd5, 32'd6, -32'd10, 32'd3);
        add_op(MODE_NEG, 32'd6, -32'd4, 32'hdead_beef, 32'd0);
        add_op(3'd5, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
        add_op(3'd6, 32'd0, 32'd7, 32'd1, 32'd1);
        add_op(3'd7, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
        add_op(MODE_ADD, 32'd3, 32'd0, 32'd1, 32'd1);
        add_op(MODE_SUB, 32'd3, 32'd5, 32'd1, 32'd0);
        add_op(MODE_DIV, 32'd3, 32'd5, 32'd0, 32'd2);
        add_op(MODE_NEG, 32'd3, 32'd0, 32'd1, 32'd1);
        add_op(MODE_MUL, 32'd0, 32'd6, 32'd5, 32'd8);
        add_op(MODE_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        add_op(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_op(MODE_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        add_op(MODE_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        add_op(MODE_SUB, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'hffff_ffff);
        add_op(MODE_DIV, 32'h8000_0000, 32'd3, 32'hffff_ffff, 32'd3);
        add_op(MODE_NEG, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
        add_op(MODE_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        add_op(MODE_DIV, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555);
        add_op(MODE_SUB, 32'd7, -32'd14, -32'd7, 32'd14);
        add_op(MODE_MUL, 32'd12, 32'd18, 32'd0, -32'd5);
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3));
            add_op(mode, random_operand(), random_operand(), random_operand(),
                   random_operand());
            if (i == NUM_RANDOM - 150)
            begin
                wait (pending_ops.size() == 0);
                quiet_phase = 1'b1;
            end
        end
        wait (pending_ops.size() == 0 && !s_tvalid && expected_fracs.size() == 0);
        repeat (250) @(posedge clk);
        if (error_count == 0)
            $display("** rational_arith_unit_top: PASSED **");
        else
            $display("** rational_arith_unit_top: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire
